// ----- rtl/core/gap_buffer_text_store_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the gap buffer text store
// Helpers that wrap clocked concurrent assertions with the reset disable.
// ----------------------------------------------------------------------------
`ifndef GAP_BUFFER_TEXT_STORE_ASSERT_SVH
`define GAP_BUFFER_TEXT_STORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GBTS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GBTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/gbts_pkg.sv -----
// ----------------------------------------------------------------------------
// Gap buffer text store package
// Field widths, default sizes, action and status codes.
// ----------------------------------------------------------------------------
package gbts_pkg;

  localparam int ACTION_W = 2;
  localparam int POS_W    = 13;
  localparam int CNT_W    = 7;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 13;

  localparam int DEF_CAPACITY = 4096;
  localparam int DEF_MAX_RUN  = 64;

  typedef enum logic [ACTION_W-1:0] {
    ACT_READ   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2
  } action_t;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

endpackage

// ----- rtl/core/gbts_if.sv -----
// ----------------------------------------------------------------------------
// Gap buffer text store channels
// Valid/ready interfaces for the request and the result channel.
// ----------------------------------------------------------------------------
interface gbts_in_if;
  import gbts_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [POS_W-1:0]    position;
  logic [CNT_W-1:0]    count;
  logic [BYTE_W-1:0]   data;

  modport source (output valid, action, position, count, data, input ready);
  modport sink   (input valid, action, position, count, data, output ready);
endinterface

interface gbts_out_if;
  import gbts_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_byte;
  logic [CNT_W-1:0]  amount;
  logic              last;
  logic              status;
  logic [LEN_W-1:0]  length;

  modport source (output valid, read_byte, amount, last, status, length, input ready);
  modport sink   (input valid, read_byte, amount, last, status, length, output ready);
endinterface

// ----- rtl/core/gbts_mem.sv -----
// ----------------------------------------------------------------------------
// Gap buffer text store memory
// Byte array with one write port and one registered read port.
// ----------------------------------------------------------------------------
module gbts_mem #(
  parameter int  DEPTH = gbts_pkg::DEF_CAPACITY,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [gbts_pkg::BYTE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [gbts_pkg::BYTE_W-1:0] rd_data
);
  import gbts_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds between reads so a result can wait for the sink.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/gbts_engine.sv -----
// ----------------------------------------------------------------------------
// Gap buffer text store engine
// Sequencer for gap moves, fills and reads, with the result register.
// ----------------------------------------------------------------------------
module gbts_engine #(
  parameter int  CAPACITY = gbts_pkg::DEF_CAPACITY,
  parameter int  MAX_RUN  = gbts_pkg::DEF_MAX_RUN,
  localparam int AW       = $clog2(CAPACITY)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  gbts_in_if.sink                     in_ch,
  gbts_out_if.source                  out_ch,
  output logic                        mem_wr_en,
  output logic [AW-1:0]               mem_wr_addr,
  output logic [gbts_pkg::BYTE_W-1:0] mem_wr_data,
  output logic                        mem_rd_en,
  output logic [AW-1:0]               mem_rd_addr,
  input  logic [gbts_pkg::BYTE_W-1:0] mem_rd_data
);
  import gbts_pkg::*;

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int RW = $clog2(MAX_RUN + 1);
  localparam int CW = (LW > POS_W) ? LW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_MOVE, S_FILL, S_DEL_FIN, S_RD_ISSUE, S_RD_EMIT, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  logic [ACTION_W-1:0] act_r, act_nxt;
  logic [LW-1:0]       pos_r, pos_nxt;
  logic [RW-1:0]       cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]   data_r, data_nxt;
  logic [LW-1:0]       gs_r, gs_nxt;
  logic [LW-1:0]       hi_r, hi_nxt;
  logic [LW-1:0]       len_r, len_nxt;
  logic [LW-1:0]       gap_r, gap_nxt;
  logic [LW-1:0]       tgt_r, tgt_nxt;
  logic [RW-1:0]       rem_r, rem_nxt;
  logic [RW-1:0]       amt_r, amt_nxt;
  logic                st_r, st_nxt;
  logic [LW-1:0]       lg_r, lg_nxt;
  logic [LW-1:0]       ph_r, ph_nxt;
  logic                mv_pend_r, mv_pend_nxt;
  logic [AW-1:0]       mv_dst_r, mv_dst_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic [CNT_W-1:0]    out_amount_r, out_amount_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_status_r, out_status_nxt;
  logic [LEN_W-1:0]    out_length_r, out_length_nxt;

  logic                out_free;
  logic [LW-1:0]       avail;
  logic [LW-1:0]       lg_inc;
  logic [LW-1:0]       gs_dec;
  logic [LW-1:0]       hi_dec;

  assign out_free = !out_valid_r || out_ch.ready;
  assign avail    = len_r - pos_r;
  assign lg_inc   = lg_r + LW'(1);
  assign gs_dec   = gs_r - LW'(1);
  assign hi_dec   = hi_r - LW'(1);

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    data_nxt       = data_r;
    gs_nxt         = gs_r;
    hi_nxt         = hi_r;
    len_nxt        = len_r;
    gap_nxt        = gap_r;
    tgt_nxt        = tgt_r;
    rem_nxt        = rem_r;
    amt_nxt        = amt_r;
    st_nxt         = st_r;
    lg_nxt         = lg_r;
    ph_nxt         = ph_r;
    mv_pend_nxt    = mv_pend_r;
    mv_dst_nxt     = mv_dst_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_byte_nxt   = out_byte_r;
    out_amount_nxt = out_amount_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    out_length_nxt = out_length_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = mv_dst_r;
    mem_wr_data    = mem_rd_data;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = AW'(ph_r);

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          act_nxt  = in_ch.action;
          data_nxt = in_ch.data;
          pos_nxt  = (CW'(in_ch.position) > CW'(len_r)) ? len_r : LW'(in_ch.position);
          cnt_nxt  = (in_ch.count > CNT_W'(MAX_RUN)) ? RW'(MAX_RUN) : RW'(in_ch.count);
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        amt_nxt = RW'(0);
        st_nxt  = ST_OK;
        case (act_r)
          ACT_READ: begin
            if (LW'(cnt_r) > avail) begin
              amt_nxt = RW'(avail);
              rem_nxt = RW'(avail);
            end else begin
              amt_nxt = cnt_r;
              rem_nxt = cnt_r;
            end
            lg_nxt = pos_r;
            ph_nxt = (pos_r < gs_r) ? pos_r : pos_r + gap_r;
            if (avail == LW'(0) || cnt_r == RW'(0)) begin
              amt_nxt   = RW'(0);
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_RD_ISSUE;
            end
          end
          ACT_INSERT: begin
            if (LW'(cnt_r) > gap_r) begin
              st_nxt    = ST_FULL;
              state_nxt = S_EMIT;
            end else begin
              amt_nxt   = cnt_r;
              rem_nxt   = cnt_r;
              tgt_nxt   = pos_r;
              state_nxt = S_MOVE;
            end
          end
          ACT_DELETE: begin
            amt_nxt   = (LW'(cnt_r) > avail) ? RW'(avail) : cnt_r;
            tgt_nxt   = pos_r;
            state_nxt = S_MOVE;
          end
          default: begin
            state_nxt = S_EMIT;
          end
        endcase
      end

      // One byte crosses the gap per cycle; each write follows its read in the next cycle.
      S_MOVE: begin
        mem_wr_en = mv_pend_r;
        if (gs_r < tgt_r) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = AW'(hi_r);
          mv_dst_nxt  = AW'(gs_r);
          mv_pend_nxt = 1'b1;
          gs_nxt      = gs_r + LW'(1);
          hi_nxt      = hi_r + LW'(1);
        end else if (gs_r > tgt_r) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = AW'(gs_dec);
          mv_dst_nxt  = AW'(hi_dec);
          mv_pend_nxt = 1'b1;
          gs_nxt      = gs_dec;
          hi_nxt      = hi_dec;
        end else begin
          mv_pend_nxt = 1'b0;
          state_nxt   = (act_r == ACT_INSERT) ? S_FILL : S_DEL_FIN;
        end
      end

      S_FILL: begin
        if (rem_r == RW'(0)) begin
          state_nxt = S_EMIT;
        end else begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = AW'(gs_r);
          mem_wr_data = data_r;
          gs_nxt      = gs_r + LW'(1);
          len_nxt     = len_r + LW'(1);
          gap_nxt     = gap_r - LW'(1);
          rem_nxt     = rem_r - RW'(1);
        end
      end

      S_DEL_FIN: begin
        hi_nxt    = hi_r + LW'(amt_r);
        len_nxt   = len_r - LW'(amt_r);
        gap_nxt   = gap_r + LW'(amt_r);
        state_nxt = S_EMIT;
      end

      S_RD_ISSUE: begin
        mem_rd_en = 1'b1;
        lg_nxt    = lg_inc;
        // Logical bytes at and above the gap start live above the gap.
        ph_nxt    = (lg_inc == gs_r) ? hi_r : ph_r + LW'(1);
        state_nxt = S_RD_EMIT;
      end

      S_RD_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = mem_rd_data;
          out_amount_nxt = CNT_W'(amt_r);
          out_last_nxt   = (rem_r == RW'(1));
          out_status_nxt = ST_OK;
          out_length_nxt = LEN_W'(len_r);
          rem_nxt        = rem_r - RW'(1);
          state_nxt      = (rem_r == RW'(1)) ? S_IDLE : S_RD_ISSUE;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = '0;
          out_amount_nxt = CNT_W'(amt_r);
          out_last_nxt   = 1'b1;
          out_status_nxt = st_r;
          out_length_nxt = LEN_W'(len_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gs_r        <= '0;
      hi_r        <= LW'(CAPACITY);
      len_r       <= '0;
      gap_r       <= LW'(CAPACITY);
      mv_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gs_r        <= gs_nxt;
      hi_r        <= hi_nxt;
      len_r       <= len_nxt;
      gap_r       <= gap_nxt;
      mv_pend_r   <= mv_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r        <= act_nxt;
    pos_r        <= pos_nxt;
    cnt_r        <= cnt_nxt;
    data_r       <= data_nxt;
    tgt_r        <= tgt_nxt;
    rem_r        <= rem_nxt;
    amt_r        <= amt_nxt;
    st_r         <= st_nxt;
    lg_r         <= lg_nxt;
    ph_r         <= ph_nxt;
    mv_dst_r     <= mv_dst_nxt;
    out_byte_r   <= out_byte_nxt;
    out_amount_r <= out_amount_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
    out_length_r <= out_length_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_byte = out_byte_r;
  assign out_ch.amount    = out_amount_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.length    = out_length_r;

endmodule

// ----- rtl/core/gap_buffer_text_store.sv -----
// ----------------------------------------------------------------------------
// Gap buffer text store
// Byte text store kept as a gap buffer; serves read, insert and delete.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  in_ch     sink       action, position, count, data (one request per transfer)
//  out_ch    source     read_byte, amount, last, status, length
//
//  A request is taken only when the engine is idle; results leave through one
//  output register, so a finished request frees the input while its last result
//  waits. An insert or a delete first moves the gap to its position with the
//  one-byte-per-cycle gap copy; a refused insert, an unused code or an empty
//  read gives a single result without a gap move. Reset clears the gap, the
//  length and the state, not the memory; a stalled sink delays each result.
// ----------------------------------------------------------------------------
`include "gap_buffer_text_store_assert.svh"

module gap_buffer_text_store #(
  parameter int CAPACITY = gbts_pkg::DEF_CAPACITY,
  parameter int MAX_RUN  = gbts_pkg::DEF_MAX_RUN
) (
  input  logic       clk,
  input  logic       rst_n,
  gbts_in_if.sink    in_ch,
  gbts_out_if.source out_ch
);
  import gbts_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [BYTE_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic [BYTE_W-1:0] mem_rd_data;

  gbts_engine #(
    .CAPACITY (CAPACITY),
    .MAX_RUN  (MAX_RUN)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  gbts_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  `GBTS_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "ready after accept")
  `GBTS_ASSERT_SAME(a_full_moves_nothing, out_ch.valid && out_ch.status == ST_FULL, out_ch.amount == '0, "refused insert with amount")
  `GBTS_ASSERT_SAME(a_full_is_last, out_ch.valid && !out_ch.last, out_ch.status == ST_OK, "refusal not last")

endmodule

// ----- tb/gap_buffer_text_store_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gap buffer text store testbench
// Drives read, insert and delete requests with random stalls on both channels
// and checks every result against a logical copy of the text kept as a byte
// queue. The store is grown until inserts are refused, shrunk, then mixed.
// ----------------------------------------------------------------------------
module gap_buffer_text_store_tb;
  import gbts_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int TARGET_REQUESTS = 280;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int DRAIN_CYCLES    = 100;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic [CNT_W-1:0]  amount;
    logic              last;
    logic              status;
    logic [LEN_W-1:0]  length;
  } text_result_t;

  class text_store_scoreboard;
    localparam int MAX_REPORTS = 40;

    logic [BYTE_W-1:0] text_q[$];
    text_result_t      expected_q[$];
    int                errors;
    int                reported;

    function int payload_len();
      return text_q.size();
    endfunction

    function void push_result(logic [BYTE_W-1:0] rd, int amt, logic fin, logic st, int len);
      text_result_t r;
      r.read_byte = rd;
      r.amount    = amt[CNT_W-1:0];
      r.last      = fin;
      r.status    = st;
      r.length    = len[LEN_W-1:0];
      expected_q.push_back(r);
    endfunction

    // The text is kept in logical order, so the gap never shows up here.
    function void note_request(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                               logic [CNT_W-1:0] cnt, logic [BYTE_W-1:0] fill);
      int len;
      int at;
      int run;
      len = text_q.size();
      run = (cnt > DEF_MAX_RUN) ? DEF_MAX_RUN : int'(cnt);
      at  = (pos > len) ? len : int'(pos);
      case (act)
        ACT_READ: begin
          if (run > len - at) run = len - at;
          if (run == 0) push_result('0, 0, 1'b1, ST_OK, len);
          else begin
            for (int i = 0; i < run; i++)
              push_result(text_q[at + i], run, i == run - 1, ST_OK, len);
          end
        end
        ACT_INSERT: begin
          if (run > DEF_CAPACITY - len) push_result('0, 0, 1'b1, ST_FULL, len);
          else begin
            repeat (run) text_q.insert(at, fill);
            push_result('0, run, 1'b1, ST_OK, len + run);
          end
        end
        ACT_DELETE: begin
          if (run > len - at) run = len - at;
          repeat (run) text_q.delete(at);
          push_result('0, run, 1'b1, ST_OK, len - run);
        end
        default: push_result('0, 0, 1'b1, ST_OK, len);
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (reported < MAX_REPORTS) begin
        reported++;
        $display("[%0t] mismatch: %s", $time, msg);
      end
    endtask

    task check_result(text_result_t got);
      text_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.read_byte !== want.read_byte)
        report_mismatch($sformatf("read_byte %0h, expected %0h", got.read_byte, want.read_byte));
      if (got.amount !== want.amount)
        report_mismatch($sformatf("amount %0d, expected %0d", got.amount, want.amount));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %b, expected %b", got.status, want.status));
      if (got.length !== want.length)
        report_mismatch($sformatf("length %0d, expected %0d", got.length, want.length));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   requests_sent;
  int   in_calm;
  int   out_calm;
  int   quiet_cycles;

  text_store_scoreboard sb;

  gbts_in_if  in_ch ();
  gbts_out_if out_ch ();

  gap_buffer_text_store #(
    .CAPACITY (DEF_CAPACITY),
    .MAX_RUN  (DEF_MAX_RUN)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly a random wait before each item, with occasional runs of back-to-back items.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, 5);
  endfunction

  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] pos,
                              input logic [CNT_W-1:0] cnt, input logic [BYTE_W-1:0] fill);
    int pause;
    pause = draw_wait(in_calm);
    if (pause > 0) begin
      in_ch.valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.position <= pos;
    in_ch.count    <= cnt;
    in_ch.data     <= fill;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(act, pos, cnt, fill);
    requests_sent++;
  endtask

  function automatic logic [POS_W-1:0] pick_position(int len);
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 14) return POS_W'($urandom_range(0, len));
    if (roll < 16) return '0;
    if (roll < 17) return len[POS_W-1:0];
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  // Weights are percentages; whatever is left over goes to the unused action code.
  task automatic random_request(int w_read, int w_insert, int w_delete, int cnt_lo, int cnt_hi);
    int                  roll;
    logic [ACTION_W-1:0] act;
    logic [CNT_W-1:0]    cnt;
    roll = $urandom_range(0, 99);
    if (roll < w_read) act = ACT_READ;
    else if (roll < w_read + w_insert) act = ACT_INSERT;
    else if (roll < w_read + w_insert + w_delete) act = ACT_DELETE;
    else act = ACT_UNUSED;
    if ($urandom_range(0, 4) == 0) cnt = CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
    else cnt = CNT_W'($urandom_range(cnt_lo, cnt_hi));
    send_request(act, pick_position(sb.payload_len()), cnt, BYTE_W'($urandom_range(0, 255)));
  endtask

  initial begin : result_sink
    int pause;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      pause = draw_wait(out_calm);
      if (pause > 0) begin
        out_ch.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      sb.check_result({out_ch.read_byte, out_ch.amount, out_ch.last, out_ch.status,
                       out_ch.length});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, sb.expected_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int gap_left;
    sb = new();
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.action   <= ACT_READ;
    in_ch.position <= '0;
    in_ch.count    <= '0;
    in_ch.data     <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Empty store, unused code, zero-count and zero-fill inserts.
    send_request(ACT_READ,   13'd0,    7'd5,   8'h00);
    send_request(ACT_DELETE, 13'd0,    7'd10,  8'h00);
    send_request(ACT_UNUSED, 13'd8191, 7'd127, 8'hff);
    send_request(ACT_INSERT, 13'd0,    7'd0,   8'haa);
    send_request(ACT_INSERT, 13'd0,    7'd64,  8'h00);
    // Position past the end is clamped and an oversized count saturates.
    send_request(ACT_INSERT, 13'd8191, 7'd127, 8'hff);
    send_request(ACT_INSERT, 13'd64,   7'd5,   8'h55);
    send_request(ACT_READ,   13'd0,    7'd127, 8'h00);
    send_request(ACT_READ,   13'd60,   7'd10,  8'h00);
    send_request(ACT_READ,   13'd8191, 7'd3,   8'h00);
    send_request(ACT_READ,   13'd130,  7'd64,  8'h00);
    // Delete running past the end of the text is clamped.
    send_request(ACT_DELETE, 13'd100,  7'd127, 8'h00);
    send_request(ACT_DELETE, 13'd0,    7'd1,   8'h00);
    send_request(ACT_INSERT, 13'd1,    7'd1,   8'h80);
    send_request(ACT_READ,   13'd0,    7'd64,  8'h3c);
    send_request(ACT_DELETE, 13'd8191, 7'd64,  8'h00);
    send_request(ACT_READ,   13'd0,    7'd0,   8'h00);
    send_request(ACT_READ,   13'd99,   7'd1,   8'h00);
    send_request(ACT_INSERT, 13'd0,    7'd64,  8'h01);

    // Grow the text until the gap is nearly used up.
    while (sb.payload_len() < DEF_CAPACITY - 16 && requests_sent < 170)
      random_request(15, 70, 10, 24, 64);

    // If the rest of the gap fits one insert, fill it exactly; then inserts that no longer fit are refused.
    gap_left = DEF_CAPACITY - sb.payload_len();
    if (gap_left <= DEF_MAX_RUN)
      send_request(ACT_INSERT, pick_position(sb.payload_len()), gap_left[CNT_W-1:0],
                   BYTE_W'($urandom_range(0, 255)));
    send_request(ACT_INSERT, pick_position(sb.payload_len()), 7'd1, 8'h7e);
    send_request(ACT_INSERT, 13'd0, 7'd127, 8'h81);
    repeat (12) random_request(30, 40, 20, 1, 16);

    // Shrink back down, then a mixed tail.
    while (sb.payload_len() > 32 && requests_sent < 265)
      random_request(15, 15, 65, 24, 64);
    while (requests_sent < TARGET_REQUESTS)
      random_request(35, 30, 25, 0, 64);

    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/gbts_pkg.sv
rtl/core/gbts_if.sv
rtl/core/gbts_mem.sv
rtl/core/gbts_engine.sv
rtl/core/gap_buffer_text_store.sv
tb/gap_buffer_text_store_tb.sv
